// File: hdl/mcpt_pkg.sv
package mcpt_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 8;
    localparam int DONE_LSB     = 4;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_READ  = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        SEL_CTRL   = 3'd0,
        SEL_PERIOD = 3'd1,
        SEL_DUTY   = 3'd2,
        SEL_COUNT  = 3'd3,
        SEL_GLOBAL = 3'd4
    } t_sel;

    typedef struct packed {
        logic [1:0]        mode;
        logic [1:0]        channel;
        logic [2:0]        reg_sel;
        logic [DATA_W-1:0] wdata;
    } t_item;

    typedef struct packed {
        logic              tick;
        logic              wr_ctrl;
        logic              wr_period;
        logic              wr_duty;
        logic              wr_count;
        logic [DATA_W-1:0] wdata;
    } t_chan_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] ctrl;
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] duty;
        logic [DATA_W-1:0] count;
        logic              done;
    } t_chan_stat;

endpackage

// File: hdl/mcpt_if.sv
interface mcpt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [1:0] channel;
    logic [2:0] reg_sel;
    logic [31:0] wdata;

    modport source (output valid, output mode, output channel, output reg_sel,
                    output wdata, input ready);
    modport sink (input valid, input mode, input channel, input reg_sel,
                  input wdata, output ready);
endinterface

interface mcpt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] rdata;
    logic        irq;

    modport source (output valid, output rdata, output irq, input ready);
    modport sink (input valid, input rdata, input irq, output ready);
endinterface

// File: hdl/mcpt_channel.sv
module mcpt_channel (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mcpt_pkg::t_chan_cmd    i_cmd,
    output mcpt_pkg::t_chan_stat   o_stat
);

    logic [mcpt_pkg::DATA_W-1:0] r_ctrl;
    logic [mcpt_pkg::DATA_W-1:0] r_period;
    logic [mcpt_pkg::DATA_W-1:0] r_duty;
    logic [mcpt_pkg::DATA_W-1:0] r_count;
    logic [mcpt_pkg::DATA_W-1:0] n_count;
    logic [mcpt_pkg::DATA_W-1:0] count_inc;
    logic                        done;

    assign count_inc = r_count + mcpt_pkg::DATA_W'(1);

    always_comb begin
        n_count = r_count;
        done    = 1'b0;
        if (i_cmd.tick && r_ctrl[0]) begin
            if (r_period == '0) begin
                n_count = '0;
            end else if (count_inc >= r_period) begin
                // period reached: wrap and flag
                n_count = '0;
                done    = 1'b1;
            end else begin
                n_count = count_inc;
            end
        end else if (i_cmd.wr_count) begin
            n_count = i_cmd.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= '0;
            r_period <= '0;
            r_duty   <= '0;
            r_count  <= '0;
        end else begin
            if (i_cmd.wr_ctrl) begin
                r_ctrl <= i_cmd.wdata;
            end
            if (i_cmd.wr_period) begin
                r_period <= i_cmd.wdata;
            end
            if (i_cmd.wr_duty) begin
                r_duty <= i_cmd.wdata;
            end
            r_count <= n_count;
        end
    end

    assign o_stat.ctrl   = r_ctrl;
    assign o_stat.period = r_period;
    assign o_stat.duty   = r_duty;
    assign o_stat.count  = r_count;
    assign o_stat.done   = done;

endmodule

// File: hdl/multi_channel_pwm_timer.sv
// Four-channel PWM timer with a bus-style transaction interface.
// Input channel i_in carries one transaction per item: a tick (advance all
// enabled channel counters), a register read, a register write or nothing
// (MODE_NONE), selected by mode, with channel, reg_sel and wdata. Output
// channel o_out returns one transaction per input item: rdata (read data,
// else zero) and irq (OR of the sticky done bits after that item).
// Each input item is captured in an input register and processed when it
// advances to the output register; the channel registers, the done bits and
// the output register all update together on that edge. Output valid comes
// from the output register, which lies behind the input register;
// throughput is one item per cycle while the output is not stalled, set by
// the compare-and-increment of each channel counter.
// Reset (i_rst_n low, synchronous) clears all channel registers, counters,
// done bits and the valid flags of both pipeline registers.
// When the receiver holds o_out.ready low, the output transaction holds,
// the captured item waits in the input register, and i_in.ready drops once
// both registers are full; no state changes until the output drains.
module multi_channel_pwm_timer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mcpt_in_if.sink           i_in,
    mcpt_out_if.source        o_out
);

    localparam int NCH = mcpt_pkg::NUM_CHANNELS;

    mcpt_pkg::t_item              r_s1;
    logic                         r_s1_valid;
    logic [mcpt_pkg::DATA_W-1:0]  r_rdata;
    logic                         r_irq;
    logic                         r_out_valid;
    logic [NCH-1:0]               r_done;
    logic [NCH-1:0]               n_done;

    logic                         s1_adv;
    logic                         is_tick;
    logic                         is_read;
    logic                         is_write;
    logic [mcpt_pkg::STATUS_W-1:0] global_stat;
    logic [mcpt_pkg::DATA_W-1:0]  rd;

    mcpt_pkg::t_chan_cmd          chan_cmd  [NCH];
    mcpt_pkg::t_chan_stat         chan_stat [NCH];

    assign s1_adv     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_adv;

    assign is_tick  = mcpt_pkg::t_mode'(r_s1.mode) == mcpt_pkg::MODE_TICK;
    assign is_read  = mcpt_pkg::t_mode'(r_s1.mode) == mcpt_pkg::MODE_READ;
    assign is_write = mcpt_pkg::t_mode'(r_s1.mode) == mcpt_pkg::MODE_WRITE;

    for (genvar k = 0; k < NCH; k++) begin : g_chan
        logic wr_sel;
        assign wr_sel = s1_adv && is_write && (r_s1.channel == 2'(k));

        assign chan_cmd[k].tick      = s1_adv && is_tick;
        assign chan_cmd[k].wr_ctrl   = wr_sel &&
            (mcpt_pkg::t_sel'(r_s1.reg_sel) == mcpt_pkg::SEL_CTRL);
        assign chan_cmd[k].wr_period = wr_sel &&
            (mcpt_pkg::t_sel'(r_s1.reg_sel) == mcpt_pkg::SEL_PERIOD);
        assign chan_cmd[k].wr_duty   = wr_sel &&
            (mcpt_pkg::t_sel'(r_s1.reg_sel) == mcpt_pkg::SEL_DUTY);
        assign chan_cmd[k].wr_count  = wr_sel &&
            (mcpt_pkg::t_sel'(r_s1.reg_sel) == mcpt_pkg::SEL_COUNT);
        assign chan_cmd[k].wdata     = r_s1.wdata;

        mcpt_channel u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (chan_cmd[k]),
            .o_stat  (chan_stat[k])
        );
    end

    // enable mirror in the low nibble, done bits above it
    always_comb begin
        global_stat = '0;
        for (int k = 0; k < NCH; k++) begin
            global_stat[k]                     = chan_stat[k].ctrl[0];
            global_stat[mcpt_pkg::DONE_LSB + k] = r_done[k];
        end
    end

    always_comb begin
        n_done = r_done;
        for (int k = 0; k < NCH; k++) begin
            if (chan_stat[k].done) begin
                n_done[k] = 1'b1;
            end
        end
        // write-1-to-clear on the global register
        if (s1_adv && is_write &&
            mcpt_pkg::t_sel'(r_s1.reg_sel) == mcpt_pkg::SEL_GLOBAL) begin
            for (int k = 0; k < NCH; k++) begin
                if (r_s1.wdata[mcpt_pkg::DONE_LSB + k]) begin
                    n_done[k] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        rd = '0;
        if (is_read) begin
            case (mcpt_pkg::t_sel'(r_s1.reg_sel))
                mcpt_pkg::SEL_GLOBAL: begin
                    rd = mcpt_pkg::DATA_W'(global_stat);
                end
                mcpt_pkg::SEL_CTRL: begin
                    for (int k = 0; k < NCH; k++) begin
                        if (r_s1.channel == 2'(k)) rd = chan_stat[k].ctrl;
                    end
                end
                mcpt_pkg::SEL_PERIOD: begin
                    for (int k = 0; k < NCH; k++) begin
                        if (r_s1.channel == 2'(k)) rd = chan_stat[k].period;
                    end
                end
                mcpt_pkg::SEL_DUTY: begin
                    for (int k = 0; k < NCH; k++) begin
                        if (r_s1.channel == 2'(k)) rd = chan_stat[k].duty;
                    end
                end
                mcpt_pkg::SEL_COUNT: begin
                    for (int k = 0; k < NCH; k++) begin
                        if (r_s1.channel == 2'(k)) rd = chan_stat[k].count;
                    end
                end
                default: begin
                    rd = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_done      <= '0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1.mode    <= i_in.mode;
            r_s1.channel <= i_in.channel;
            r_s1.reg_sel <= i_in.reg_sel;
            r_s1.wdata   <= i_in.wdata;
        end
        if (s1_adv) begin
            r_rdata <= rd;
            r_irq   <= |n_done;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.rdata = r_rdata;
    assign o_out.irq   = r_irq;

`ifndef NO_ASSERTIONS
    a_irq_tracks_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_irq == (|r_done)))
        else $error("irq does not match done bits");

    a_stall_holds_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> $stable(r_done))
        else $error("done bits changed while output stalled");

    a_invalid_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && is_read && (r_s1.reg_sel > 3'(mcpt_pkg::SEL_GLOBAL)))
        |=> (r_rdata == '0))
        else $error("invalid selector read returned nonzero data");
`endif

endmodule
